>>> src/tid_pkg.sv
// ----------------------------------------------------------------------------
// Three-word instruction decoder package
// Shared codes, field widths and the decoded result structure.
// ----------------------------------------------------------------------------
package tid_pkg;

    localparam int WORD_W = 16;
    localparam int ADDR_W = 48;
    localparam int IMM_W  = 32;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SUB = 2'd1;
    localparam logic [1:0] ST_BAD_GRP = 2'd2;

    localparam logic [4:0] NM_LEAB    = 5'd0;
    localparam logic [4:0] NM_MOVB    = 5'd1;
    localparam logic [4:0] NM_LEAW    = 5'd2;
    localparam logic [4:0] NM_MOVW    = 5'd3;
    localparam logic [4:0] NM_LEAD    = 5'd4;
    localparam logic [4:0] NM_MOVL    = 5'd5;
    localparam logic [4:0] NM_LEAQ    = 5'd6;
    localparam logic [4:0] NM_MOVQ    = 5'd7;
    localparam logic [4:0] NM_MOVUB   = 5'd8;
    localparam logic [4:0] NM_MOVUW   = 5'd9;
    localparam logic [4:0] NM_MOVUL   = 5'd10;
    localparam logic [4:0] NM_MOVDL   = 5'd11;
    localparam logic [4:0] NM_ADD     = 5'd12;
    localparam logic [4:0] NM_SUB     = 5'd13;
    localparam logic [4:0] NM_MULS    = 5'd14;
    localparam logic [4:0] NM_AND     = 5'd15;
    localparam logic [4:0] NM_OR      = 5'd16;
    localparam logic [4:0] NM_XOR     = 5'd17;
    localparam logic [4:0] NM_TST     = 5'd18;
    localparam logic [4:0] NM_TSTQ    = 5'd19;
    localparam logic [4:0] NM_CMPEQ   = 5'd20;
    localparam logic [4:0] NM_CMPQEQ  = 5'd21;
    localparam logic [4:0] NM_CMPHI   = 5'd22;
    localparam logic [4:0] NM_CMPQHI  = 5'd23;
    localparam logic [4:0] NM_CMPGT   = 5'd24;
    localparam logic [4:0] NM_CMPQGT  = 5'd25;
    localparam logic [4:0] NM_LDIZ    = 5'd26;
    localparam logic [4:0] NM_LDIN    = 5'd27;
    localparam logic [4:0] NM_LDISH32 = 5'd28;
    localparam logic [4:0] NM_MOV     = 5'd29;

    localparam logic [3:0] FM_LDREGDISPREG = 4'd0;
    localparam logic [3:0] FM_REGSTREGDISP = 4'd1;
    localparam logic [3:0] FM_REGIMMREG    = 4'd2;
    localparam logic [3:0] FM_IMMREG       = 4'd3;
    localparam logic [3:0] FM_IMM          = 4'd4;
    localparam logic [3:0] FM_REGSTPCDISP  = 4'd5;
    localparam logic [3:0] FM_LDPCDISPREG  = 4'd6;
    localparam logic [3:0] FM_IMMZREG      = 4'd7;
    localparam logic [3:0] FM_IMMNREG      = 4'd8;

    localparam logic [5:0] REG_PC = 6'd32;

    localparam logic [1:0] PM_NONE  = 2'd0;
    localparam logic [1:0] PM_TRUE  = 2'd1;
    localparam logic [1:0] PM_FALSE = 2'd2;

    typedef struct packed {
        logic [1:0]       status;
        logic [4:0]       mnemonic;
        logic [3:0]       operand_form;
        logic [4:0]       dest_reg;
        logic [5:0]       src_reg;
        logic [IMM_W-1:0] immediate;
        logic [1:0]       predicate_mode;
    } dec_result_t;

    function automatic logic [4:0] size_plain(input logic [1:0] idx);
        logic [4:0] nm;
        unique case (idx)
            2'd0: nm = NM_MOVB;
            2'd1: nm = NM_MOVW;
            2'd2: nm = NM_MOVL;
            default: nm = NM_MOVQ;
        endcase
        return nm;
    endfunction

    function automatic logic [4:0] size_lea(input logic [1:0] idx);
        logic [4:0] nm;
        unique case (idx)
            2'd0: nm = NM_LEAB;
            2'd1: nm = NM_LEAW;
            2'd2: nm = NM_LEAD;
            default: nm = NM_LEAQ;
        endcase
        return nm;
    endfunction

    function automatic logic [4:0] size_unsig(input logic [1:0] idx);
        logic [4:0] nm;
        unique case (idx)
            2'd0: nm = NM_MOVUB;
            2'd1: nm = NM_MOVUW;
            2'd2: nm = NM_MOVUL;
            default: nm = NM_MOVDL;
        endcase
        return nm;
    endfunction

endpackage

>>> src/triword_instruction_decoder.sv
// ----------------------------------------------------------------------------
// Three-word instruction decoder
// Decodes a 48-bit instruction into operation, operand form, registers and
// an extended immediate.
// ----------------------------------------------------------------------------
// A request is presented on word_one, word_two, word_three, fetch_address
// and predicated together with start, and is taken at a clock edge where
// start is high and busy is low. The block never stalls, so busy stays low
// and a new request may follow in every cycle.
// Each request is captured in an input register, decoded by shallow field
// logic and captured in a result register. The result appears in the result
// register with done high for exactly one cycle, and results leave in request
// order at one per cycle.
// The receiver cannot hold results off; it must take each one while done
// is high.
// The swap_store_fields register is written through cfg_write and cfg_data
// and should change only while no request is in flight.
// Reset clears the register and all valid flags; no request is in flight
// after reset.
// ----------------------------------------------------------------------------
module triword_instruction_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tid_pkg::WORD_W-1:0] word_one,
    input  logic [tid_pkg::WORD_W-1:0] word_two,
    input  logic [tid_pkg::WORD_W-1:0] word_three,
    input  logic [tid_pkg::ADDR_W-1:0] fetch_address,
    input  logic                       predicated,
    input  logic                       cfg_write,
    input  logic                       cfg_data,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [4:0]                 mnemonic,
    output logic [3:0]                 operand_form,
    output logic [4:0]                 dest_reg,
    output logic [5:0]                 src_reg,
    output logic signed [tid_pkg::IMM_W-1:0] immediate,
    output logic [1:0]                 predicate_mode,
    output logic [tid_pkg::ADDR_W-1:0] address_out
);
    import tid_pkg::*;

    logic              swap_reg;
    logic              in_valid_reg;
    logic [WORD_W-1:0] w1_reg;
    logic [WORD_W-1:0] w2_reg;
    logic [WORD_W-1:0] w3_reg;
    logic [ADDR_W-1:0] addr_in_reg;
    logic              pred_reg;
    logic              done_reg;
    dec_result_t       dec;
    dec_result_t       res_reg;
    logic [ADDR_W-1:0] addr_out_reg;
    logic              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg     <= 1'b0;
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                swap_reg <= cfg_data;
            end
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w1_reg      <= word_one;
            w2_reg      <= word_two;
            w3_reg      <= word_three;
            addr_in_reg <= fetch_address;
            pred_reg    <= predicated;
        end
        if (in_valid_reg)
        begin
            res_reg      <= dec;
            addr_out_reg <= addr_in_reg;
        end
    end

    tid_decode u_decode (
        .word_one          (w1_reg),
        .word_two          (w2_reg),
        .word_three        (w3_reg),
        .predicated        (pred_reg),
        .swap_store_fields (swap_reg),
        .result            (dec)
    );

    assign done           = done_reg;
    assign status         = res_reg.status;
    assign mnemonic       = res_reg.mnemonic;
    assign operand_form   = res_reg.operand_form;
    assign dest_reg       = res_reg.dest_reg;
    assign src_reg        = res_reg.src_reg;
    assign immediate      = $signed(res_reg.immediate);
    assign predicate_mode = res_reg.predicate_mode;
    assign address_out    = addr_out_reg;

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("request did not produce a result two cycles later");

    a_fail_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> mnemonic == 5'd0 && operand_form == 4'd0
            && dest_reg == 5'd0 && src_reg == 6'd0 && immediate == 32'sd0)
        else $error("failed decode left result fields set");

    a_pc_base_form: assert property (@(posedge clk) disable iff (!rst_n)
        done && src_reg == REG_PC |-> status == ST_OK
            && (operand_form == FM_REGSTPCDISP || operand_form == FM_LDPCDISPREG))
        else $error("program counter base with a non PC-relative form");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without a matching request");

endmodule

>>> src/tid_decode.sv
// ----------------------------------------------------------------------------
// Instruction field decoder
// Combinational decode of one registered three-word instruction.
// ----------------------------------------------------------------------------
module tid_decode (
    input  logic [tid_pkg::WORD_W-1:0] word_one,
    input  logic [tid_pkg::WORD_W-1:0] word_two,
    input  logic [tid_pkg::WORD_W-1:0] word_three,
    input  logic                       predicated,
    input  logic                       swap_store_fields,
    output tid_pkg::dec_result_t       result
);
    import tid_pkg::*;

    logic              swap_hit;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    logic [4:0]        rn_d;
    logic [4:0]        rm_d;
    logic [4:0]        rd_short;
    logic [IMM_W-1:0]  imm32;
    logic [IMM_W-1:0]  imm24;
    logic [IMM_W-1:0]  d17s;
    logic [IMM_W-1:0]  d17u;
    logic              eq;
    logic [3:0]        sub;
    logic [3:0]        pc_op;
    logic [3:0]        alu_code;
    dec_result_t       raw;

    assign swap_hit = swap_store_fields && (word_one[15:3] == 13'h1F80)
                      && (word_two[15:11] == 5'd0);
    assign w1 = swap_hit ? {word_one[15:3], word_one[1], word_one[2], word_one[0]} : word_one;
    assign w2 = swap_hit ? {word_two[15:8], word_two[3:0], word_two[7:4]} : word_two;
    assign w3 = word_three;

    assign rn_d     = {w1[2], w2[7:4]};
    assign rm_d     = {w1[1], w2[3:0]};
    assign rd_short = {w1[8], w1[3:0]};
    assign imm32    = {w3, w2};
    assign imm24    = {{8{w2[7]}}, w2[7:0], w3};
    assign d17s     = {{16{w1[0]}}, w3};
    assign d17u     = {15'd0, w1[0], w3};
    assign eq       = w1[3];
    assign sub      = w2[11:8];
    assign pc_op    = w2[15:12];
    assign alu_code = w2[3:0];

    always_comb
    begin
        raw = '0;
        raw.status = ST_OK;
        unique case (w1[7:4])
            4'h0:
            begin
                raw.dest_reg  = rn_d;
                raw.src_reg   = {1'b0, rm_d};
                raw.immediate = d17s;
                if (w2[15:12] == 4'd0)
                begin
                    priority if (sub[3:2] == 2'b00)
                    begin
                        raw.mnemonic     = eq ? size_lea(sub[1:0]) : size_plain(sub[1:0]);
                        raw.operand_form = eq ? FM_LDREGDISPREG : FM_REGSTREGDISP;
                    end
                    else if (sub[3:2] == 2'b10)
                    begin
                        raw.mnemonic     = eq ? size_unsig(sub[1:0]) : size_plain(sub[1:0]);
                        raw.operand_form = FM_LDREGDISPREG;
                    end
                    else
                    begin
                        raw.status = ST_BAD_SUB;
                    end
                end
                else if (w2[15:12] == 4'd1)
                begin
                    priority if (sub[3] == 1'b0)
                    begin
                        raw.operand_form = FM_REGIMMREG;
                        if (sub[1:0] == 2'd0 || sub[2] == 1'b0 && sub[1:0] != 2'd3)
                        begin
                            if (sub[2:1] == 2'b00)
                            begin
                                raw.immediate = d17u;
                            end
                        end
                        unique case (sub[2:0])
                            3'd0: raw.mnemonic = NM_ADD;
                            3'd1: raw.mnemonic = NM_SUB;
                            3'd2: raw.mnemonic = NM_MULS;
                            3'd5: raw.mnemonic = NM_AND;
                            3'd6: raw.mnemonic = NM_OR;
                            3'd7: raw.mnemonic = NM_XOR;
                            default: raw.status = ST_BAD_SUB;
                        endcase
                        if (!eq)
                        begin
                            raw.status = ST_BAD_SUB;
                        end
                    end
                    else if (sub == 4'd9)
                    begin
                        raw.operand_form = FM_IMMREG;
                        unique case (alu_code)
                            4'h4: raw.mnemonic = eq ? NM_TSTQ : NM_TST;
                            4'hC: raw.mnemonic = eq ? NM_CMPQEQ : NM_CMPEQ;
                            4'hD: raw.mnemonic = eq ? NM_CMPQHI : NM_CMPHI;
                            4'hE: raw.mnemonic = eq ? NM_CMPQGT : NM_CMPGT;
                            default: raw.status = ST_BAD_SUB;
                        endcase
                    end
                    else
                    begin
                        raw.status = ST_BAD_SUB;
                    end
                end
                else
                begin
                    raw.status = ST_BAD_SUB;
                end
            end
            4'h2:
            begin
                priority if (w1[3:0] == 4'd4 || w1[3:0] == 4'd5 || w1[3:0] == 4'd6)
                begin
                    raw.immediate    = imm32;
                    raw.operand_form = FM_IMM;
                    unique case (w1[1:0])
                        2'd0: raw.mnemonic = NM_LDIZ;
                        2'd1: raw.mnemonic = NM_LDIN;
                        default: raw.mnemonic = NM_LDISH32;
                    endcase
                end
                else if (w1[3:0] == 4'd7)
                begin
                    raw.dest_reg  = {w1[8], w2[11:8]};
                    raw.src_reg   = REG_PC;
                    raw.immediate = imm24;
                    priority if (pc_op[3:2] == 2'b00)
                    begin
                        raw.mnemonic     = size_plain(pc_op[1:0]);
                        raw.operand_form = FM_REGSTPCDISP;
                    end
                    else if (pc_op == 4'd4)
                    begin
                        raw.mnemonic     = NM_LEAB;
                        raw.operand_form = FM_LDPCDISPREG;
                    end
                    else if (pc_op[3:2] == 2'b10)
                    begin
                        raw.mnemonic     = size_plain(pc_op[1:0]);
                        raw.operand_form = FM_LDPCDISPREG;
                    end
                    else if (pc_op[3:2] == 2'b11 && pc_op[1:0] != 2'd3)
                    begin
                        raw.mnemonic     = size_unsig(pc_op[1:0]);
                        raw.operand_form = FM_LDPCDISPREG;
                    end
                    else
                    begin
                        raw.status = ST_BAD_SUB;
                    end
                end
                else
                begin
                    raw.status = ST_BAD_SUB;
                end
            end
            4'hC:
            begin
                raw.mnemonic     = NM_ADD;
                raw.operand_form = FM_IMMREG;
                raw.dest_reg     = rd_short;
                raw.immediate    = imm32;
            end
            4'hD:
            begin
                raw.mnemonic     = NM_LDISH32;
                raw.operand_form = FM_IMMREG;
                raw.dest_reg     = rd_short;
                raw.immediate    = imm32;
            end
            4'hE:
            begin
                raw.mnemonic     = NM_MOV;
                raw.operand_form = FM_IMMZREG;
                raw.dest_reg     = rd_short;
                raw.immediate    = imm32;
            end
            4'hF:
            begin
                raw.mnemonic     = NM_MOV;
                raw.operand_form = FM_IMMNREG;
                raw.dest_reg     = rd_short;
                raw.immediate    = imm32;
            end
            default:
            begin
                raw.status = ST_BAD_GRP;
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        result.status = raw.status;
        if (raw.status == ST_OK)
        begin
            result = raw;
        end
        priority if (!predicated)
        begin
            result.predicate_mode = PM_NONE;
        end
        else if (w1[9])
        begin
            result.predicate_mode = PM_FALSE;
        end
        else
        begin
            result.predicate_mode = PM_TRUE;
        end
    end

endmodule
